FILE: rtl/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg
// Shared constants, register map and pixel classification for the green line
// classifier.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int LINE_PIXELS  = 80;
  localparam int CENTRE_START = 38;
  localparam int CENTRE_WIDTH = 6;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0] LINE_LEN   = 8'(LINE_PIXELS);
  localparam logic [7:0] HALF_LEN   = 8'(LINE_PIXELS / 2);
  localparam logic [8:0] CENTRE_LO  = 9'(CENTRE_START);
  localparam logic [8:0] CENTRE_HI  = 9'(CENTRE_START + CENTRE_WIDTH);
  localparam logic [2:0] CENTRE_MAX = 3'(CENTRE_WIDTH);

  localparam logic [7:0] GREEN_MARGIN_RST     = 8'd20;
  localparam logic [2:0] CENTRE_THRESHOLD_RST = 3'd3;
  localparam logic [7:0] STOP_COUNT_RST       = 8'd75;
  localparam logic [7:0] SLOW_COUNT_RST       = 8'd40;
  localparam logic [7:0] MID_COUNT_RST        = 8'd20;
  localparam logic [9:0] SLOW_SPEED_RST       = 10'd500;
  localparam logic [9:0] MID_SPEED_RST        = 10'd750;
  localparam logic [9:0] FAST_SPEED_RST       = 10'd1000;

  typedef enum logic [2:0] {
    REG_GREEN_MARGIN     = 3'd0,
    REG_CENTRE_THRESHOLD = 3'd1,
    REG_STOP_COUNT       = 3'd2,
    REG_SLOW_COUNT       = 3'd3,
    REG_MID_COUNT        = 3'd4,
    REG_SLOW_SPEED       = 3'd5,
    REG_MID_SPEED        = 3'd6,
    REG_FAST_SPEED       = 3'd7
  } cfg_reg_t;

  // Red is the top five bits of the first byte; green spans both bytes.
  function automatic logic is_green(input logic [15:0] px, input logic [7:0] margin);
    logic [7:0] red;
    logic [7:0] grn;
    red = {px[15:11], 3'b000};
    grn = {px[10:8], px[7:5], 2'b00};
    return {1'b0, grn} > ({1'b0, red} + {1'b0, margin});
  endfunction

endpackage

FILE: rtl/green_line_classifier.sv
// Result path: a pixel transaction carrying line_end is captured in the input
// register, then its count update is written into the result register.
// Throughput: one pixel per cycle; a line-end pixel waiting on an unaccepted
// result holds the input register and stalls the input.
// Reset: synchronous rst clears all counts, valid flags and restores the
// configuration registers to their default values.
// ----------------------------------------------------------------------------
// green_line_classifier
// Counts green pixels over a camera line and reports steering and speed
// decisions at the end of each line.
// ----------------------------------------------------------------------------
module green_line_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [glc_pkg::ADDR_W-1:0] paddr,
  input  logic [glc_pkg::DATA_W-1:0] pwdata,
  output logic [glc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       pixel_valid,
  output logic                       pixel_ready,
  input  logic [15:0]                pixel,
  input  logic                       line_end,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic                       green_seen,
  output logic                       centre_hit,
  output logic                       turn_right,
  output logic [9:0]                 speed,
  output logic                       stop,
  output logic [7:0]                 green_total
);
  import glc_pkg::*;

  logic [7:0] green_margin;
  logic [2:0] centre_threshold;
  logic [7:0] stop_count;
  logic [7:0] slow_count;
  logic [7:0] mid_count;
  logic [9:0] slow_speed;
  logic [9:0] mid_speed;
  logic [9:0] fast_speed;

  logic        cfg_wr;
  cfg_reg_t    cfg_sel;

  logic        s1_valid;
  logic [15:0] s1_pixel;
  logic        s1_line_end;
  logic        s1_advance;

  logic [7:0]  pixel_index;
  logic [7:0]  total_green;
  logic [7:0]  left_green;
  logic [7:0]  right_green;
  logic [2:0]  centre_green;

  logic        pos_ok;
  logic        hit;
  logic        in_left;
  logic        in_centre;
  logic [7:0]  total_next;
  logic [7:0]  left_next;
  logic [7:0]  right_next;
  logic [2:0]  centre_next;
  logic        stop_next;
  logic [9:0]  speed_next;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      green_margin     <= GREEN_MARGIN_RST;
      centre_threshold <= CENTRE_THRESHOLD_RST;
      stop_count       <= STOP_COUNT_RST;
      slow_count       <= SLOW_COUNT_RST;
      mid_count        <= MID_COUNT_RST;
      slow_speed       <= SLOW_SPEED_RST;
      mid_speed        <= MID_SPEED_RST;
      fast_speed       <= FAST_SPEED_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_GREEN_MARGIN:     green_margin     <= pwdata[7:0];
        REG_CENTRE_THRESHOLD: centre_threshold <= pwdata[2:0];
        REG_STOP_COUNT:       stop_count       <= pwdata[7:0];
        REG_SLOW_COUNT:       slow_count       <= pwdata[7:0];
        REG_MID_COUNT:        mid_count        <= pwdata[7:0];
        REG_SLOW_SPEED:       slow_speed       <= pwdata[9:0];
        REG_MID_SPEED:        mid_speed        <= pwdata[9:0];
        REG_FAST_SPEED:       fast_speed       <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_GREEN_MARGIN:     prdata = {24'd0, green_margin};
      REG_CENTRE_THRESHOLD: prdata = {29'd0, centre_threshold};
      REG_STOP_COUNT:       prdata = {24'd0, stop_count};
      REG_SLOW_COUNT:       prdata = {24'd0, slow_count};
      REG_MID_COUNT:        prdata = {24'd0, mid_count};
      REG_SLOW_SPEED:       prdata = {22'd0, slow_speed};
      REG_MID_SPEED:        prdata = {22'd0, mid_speed};
      REG_FAST_SPEED:       prdata = {22'd0, fast_speed};
      default:              prdata = '0;
    endcase
  end

  // A line-end transaction needs the result register free; others never stall.
  assign s1_advance  = s1_valid && (!s1_line_end || !result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      s1_pixel    <= pixel;
      s1_line_end <= line_end;
    end
  end

  always_comb begin
    pos_ok      = pixel_index < LINE_LEN;
    hit         = pos_ok && is_green(s1_pixel, green_margin);
    in_left     = pixel_index < HALF_LEN;
    in_centre   = ({1'b0, pixel_index} >= CENTRE_LO) && ({1'b0, pixel_index} < CENTRE_HI);
    total_next  = total_green + 8'(hit);
    left_next   = left_green + 8'(hit && in_left);
    right_next  = right_green + 8'(hit && !in_left);
    centre_next = centre_green + 3'(hit && in_centre);
    stop_next   = total_next >= stop_count;
    if (stop_next) begin
      speed_next = '0;
    end else if (total_next > slow_count) begin
      speed_next = slow_speed;
    end else if (total_next > mid_count) begin
      speed_next = mid_speed;
    end else begin
      speed_next = fast_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index  <= '0;
      total_green  <= '0;
      left_green   <= '0;
      right_green  <= '0;
      centre_green <= '0;
    end else if (s1_advance) begin
      if (s1_line_end) begin
        pixel_index  <= '0;
        total_green  <= '0;
        left_green   <= '0;
        right_green  <= '0;
        centre_green <= '0;
      end else begin
        if (pos_ok) begin
          pixel_index <= pixel_index + 8'd1;
        end
        total_green  <= total_next;
        left_green   <= left_next;
        right_green  <= right_next;
        centre_green <= centre_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && s1_line_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_line_end) begin
      green_seen  <= total_next != 8'd0;
      centre_hit  <= centre_next > centre_threshold;
      turn_right  <= left_next < right_next;
      speed       <= speed_next;
      stop        <= stop_next;
      green_total <= total_next;
    end
  end

`ifndef SYNTHESIS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_index <= LINE_LEN)
    else $error("pixel index ran past the line length");

  a_centre_bound: assert property (@(posedge clk) disable iff (rst)
    centre_green <= CENTRE_MAX)
    else $error("centre count exceeds the window width");

  a_halves_sum: assert property (@(posedge clk) disable iff (rst)
    {1'b0, total_green} == ({1'b0, left_green} + {1'b0, right_green}))
    else $error("half counts do not add up to the total");

  a_clear_after_line: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_line_end |=> pixel_index == '0 && total_green == '0)
    else $error("counts not cleared after line end");

  a_stop_speed: assert property (@(posedge clk) disable iff (rst)
    result_valid && stop |-> speed == '0)
    else $error("nonzero speed with stop asserted");

  a_seen_total: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> green_seen == (green_total != '0))
    else $error("green_seen disagrees with green_total");
`endif

endmodule
